[sv/dnt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnt_pkg: shared types and codes for the directory name table
// Request and status codes, controller states and the command and status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package dnt_pkg;

  localparam int WORD_W   = 64;
  localparam int NAME_W   = 4 * WORD_W;
  localparam int INODE_W  = 16;
  localparam int OP_W     = 3;
  localparam int STATUS_W = 2;

  localparam logic [OP_W-1:0] OP_PUT    = 3'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 3'd1;
  localparam logic [OP_W-1:0] OP_LOOKUP = 3'd2;
  localparam logic [OP_W-1:0] OP_LIST   = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EXISTS    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_WRITE,
    S_SHIFT,
    S_LIST_RD,
    S_LIST_OUT,
    S_RESP
  } state_t;

  typedef struct packed {
    logic                accept;
    logic                scan_start;
    logic                scan_step;
    logic                shift_start;
    logic                shift_step;
    logic                put_write;
    logic                count_inc;
    logic                count_dec;
    logic                count_clr;
    logic                list_start;
    logic                list_read;
    logic                list_load;
    logic                resp_load;
    logic [STATUS_W-1:0] resp_status;
    logic                resp_use_inode;
  } dnt_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            full;
    logic            empty;
    logic            hit;
    logic            scan_end;
    logic            out_free;
    logic            list_last;
  } dnt_stat_t;

endpackage

[sv/dnt_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnt_datapath: storage, scan pipeline and result register
// Holds the name and inode memories, the entry count, the request register,
// the read/compare pipeline used for search and shift, and the output stage.
// ----------------------------------------------------------------------------
module dnt_datapath import dnt_pkg::*; #(
  parameter int ENTRIES    = 16,
  parameter int NAME_BYTES = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  dnt_cmd_t            cmd,
  output dnt_stat_t           stat,
  input  logic [OP_W-1:0]     req_type,
  input  logic [WORD_W-1:0]   name_word0,
  input  logic [WORD_W-1:0]   name_word1,
  input  logic [WORD_W-1:0]   name_word2,
  input  logic [WORD_W-1:0]   name_word3,
  input  logic [INODE_W-1:0]  inode_in,
  input  logic                out_stall,
  output logic                out_valid,
  output logic [STATUS_W-1:0] status,
  output logic [INODE_W-1:0]  inode_out,
  output logic [WORD_W-1:0]   out_word0,
  output logic [WORD_W-1:0]   out_word1,
  output logic [WORD_W-1:0]   out_word2,
  output logic [WORD_W-1:0]   out_word3,
  output logic                last_item
);

  localparam int CW = $clog2(ENTRIES + 1);
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int NB = NAME_BYTES * 8;

  // name normalization: cut at the first zero byte and at NAME_BYTES
  logic [NAME_W-1:0]     raw;
  logic [NAME_BYTES-1:0] nz;
  logic [NAME_BYTES-1:0] keep;
  logic [NB-1:0]         norm;

  assign raw = {name_word3, name_word2, name_word1, name_word0};

  always_comb begin
    for (int b = 0; b < NAME_BYTES; b++) begin
      nz[b] = |raw[8*b +: 8];
    end
    for (int b = 0; b < NAME_BYTES; b++) begin
      keep[b] = 1'b1;
      for (int j = 0; j < NAME_BYTES; j++) begin
        if (j <= b) keep[b] = keep[b] & nz[j];
      end
    end
    for (int b = 0; b < NAME_BYTES; b++) begin
      norm[8*b +: 8] = keep[b] ? raw[8*b +: 8] : 8'h00;
    end
  end

  logic [OP_W-1:0]    req_op;
  logic [NB-1:0]      req_name;
  logic [INODE_W-1:0] req_inode;
  logic [CW-1:0]      count;
  logic [CW-1:0]      idx;
  logic               cmp_valid;
  logic [CW-1:0]      cmp_idx;
  logic [NB-1:0]      rd_name;
  logic [INODE_W-1:0] rd_inode;
  logic [INODE_W-1:0] res_inode;
  logic [NB-1:0]      out_name;
  logic [NAME_W-1:0]  out_wide;

  logic [NB-1:0]      name_mem  [ENTRIES];
  logic [INODE_W-1:0] inode_mem [ENTRIES];

  logic               issue;
  logic               rd_en;
  logic [IW-1:0]      rd_addr;
  logic               wr_en;
  logic [IW-1:0]      wr_addr;
  logic [CW-1:0]      cmp_prev;
  logic [NB-1:0]      wr_name;
  logic [INODE_W-1:0] wr_inode;
  logic               match;
  logic               out_free;

  assign issue    = (cmd.scan_step || cmd.shift_step) && (idx < count);
  assign rd_en    = issue || cmd.list_read;
  assign rd_addr  = idx[IW-1:0];
  assign cmp_prev = cmp_idx - 1'b1;
  assign wr_en    = cmd.put_write || (cmd.shift_step && cmp_valid);
  assign wr_addr  = cmd.put_write ? count[IW-1:0] : cmp_prev[IW-1:0];
  assign wr_name  = cmd.put_write ? req_name : rd_name;
  assign wr_inode = cmd.put_write ? req_inode : rd_inode;
  assign match    = cmp_valid && (rd_name == req_name);
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      name_mem[wr_addr]  <= wr_name;
      inode_mem[wr_addr] <= wr_inode;
    end
    if (rd_en) begin
      rd_name  <= name_mem[rd_addr];
      rd_inode <= inode_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      idx       <= '0;
      cmp_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.count_clr) count <= '0;
      else if (cmd.count_inc) count <= count + 1'b1;
      else if (cmd.count_dec) count <= count - 1'b1;

      if (cmd.scan_start) idx <= '0;
      else if (cmd.shift_start) idx <= cmp_idx + 1'b1;
      else if (issue) idx <= idx + 1'b1;
      else if (cmd.list_start) idx <= count - 1'b1;
      else if (cmd.list_load) idx <= idx - 1'b1;

      if (cmd.scan_start || cmd.shift_start) cmp_valid <= 1'b0;
      else cmp_valid <= issue;

      if (cmd.resp_load || cmd.list_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_op    <= req_type;
      req_name  <= norm;
      req_inode <= inode_in;
    end
    if (issue) cmp_idx <= idx;
    if (match) res_inode <= rd_inode;
    if (cmd.resp_load) begin
      status    <= cmd.resp_status;
      inode_out <= cmd.resp_use_inode ? res_inode : '0;
      out_name  <= '0;
      last_item <= 1'b1;
    end else if (cmd.list_load) begin
      status    <= ST_OK;
      inode_out <= rd_inode;
      out_name  <= rd_name;
      last_item <= (idx == '0);
    end
  end

  assign out_wide  = NAME_W'(out_name);
  assign out_word0 = out_wide[WORD_W-1:0];
  assign out_word1 = out_wide[2*WORD_W-1:WORD_W];
  assign out_word2 = out_wide[3*WORD_W-1:2*WORD_W];
  assign out_word3 = out_wide[4*WORD_W-1:3*WORD_W];

  always_comb begin
    stat.op        = req_op;
    stat.full      = (count == CW'(ENTRIES));
    stat.empty     = (count == '0);
    stat.hit       = match;
    stat.scan_end  = !cmp_valid && (idx >= count);
    stat.out_free  = out_free;
    stat.list_last = (idx == '0);
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(ENTRIES))
    else $error("entry count above table size");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.resp_load || cmd.list_load) |-> out_free)
    else $error("result register overwritten before transfer");

  a_put_room: assert property (@(posedge clk) disable iff (rst)
    cmd.put_write |-> (count < CW'(ENTRIES)))
    else $error("append into a full table");

  a_hit_range: assert property (@(posedge clk) disable iff (rst)
    match |-> (cmp_idx < count))
    else $error("match on an entry above the count");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.count_clr |=> (count == '0))
    else $error("clear did not empty the table");

endmodule

[sv/dnt_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnt_ctrl: request sequencer for the directory name table
// Decodes the request, runs the search, append, shift and list sequences
// and hands the final status to the result register.
// ----------------------------------------------------------------------------
module dnt_ctrl import dnt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      busy,
  input  dnt_stat_t stat,
  output dnt_cmd_t  cmd
);

  state_t              state;
  state_t              state_next;
  logic [STATUS_W-1:0] code;
  logic [STATUS_W-1:0] code_next;
  logic                use_inode;
  logic                use_inode_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      code      <= ST_OK;
      use_inode <= 1'b0;
    end else begin
      state     <= state_next;
      code      <= code_next;
      use_inode <= use_inode_next;
    end
  end

  always_comb begin
    state_next     = state;
    code_next      = code;
    use_inode_next = use_inode;
    case (state)
      S_IDLE: begin
        use_inode_next = 1'b0;
        if (in_valid) state_next = S_DISPATCH;
      end
      S_DISPATCH: begin
        case (stat.op)
          OP_PUT: begin
            if (stat.full) begin
              code_next  = ST_FULL;
              state_next = S_RESP;
            end else begin
              state_next = S_SCAN;
            end
          end
          OP_DELETE, OP_LOOKUP: state_next = S_SCAN;
          OP_LIST: begin
            if (stat.empty) begin
              code_next  = ST_NOT_FOUND;
              state_next = S_RESP;
            end else begin
              state_next = S_LIST_RD;
            end
          end
          default: begin
            code_next  = ST_OK;
            state_next = S_RESP;
          end
        endcase
      end
      S_SCAN: begin
        if (stat.hit) begin
          case (stat.op)
            OP_PUT: begin
              code_next  = ST_EXISTS;
              state_next = S_RESP;
            end
            OP_DELETE: state_next = S_SHIFT;
            default: begin
              code_next      = ST_OK;
              use_inode_next = 1'b1;
              state_next     = S_RESP;
            end
          endcase
        end else if (stat.scan_end) begin
          if (stat.op == OP_PUT) begin
            state_next = S_WRITE;
          end else begin
            code_next  = ST_NOT_FOUND;
            state_next = S_RESP;
          end
        end
      end
      S_WRITE: begin
        code_next  = ST_OK;
        state_next = S_RESP;
      end
      S_SHIFT: begin
        if (stat.scan_end) begin
          code_next  = ST_OK;
          state_next = S_RESP;
        end
      end
      S_LIST_RD: state_next = S_LIST_OUT;
      S_LIST_OUT: begin
        if (stat.out_free) state_next = stat.list_last ? S_IDLE : S_LIST_RD;
      end
      S_RESP: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    busy               = (state != S_IDLE);
    cmd                = '0;
    cmd.resp_status    = code;
    cmd.resp_use_inode = use_inode;
    case (state)
      S_IDLE: cmd.accept = in_valid;
      S_DISPATCH: begin
        cmd.scan_start = (stat.op != OP_LIST);
        cmd.list_start = (stat.op == OP_LIST);
        cmd.count_clr  = (stat.op == OP_CLEAR);
      end
      S_SCAN: begin
        cmd.scan_step   = 1'b1;
        cmd.shift_start = stat.hit && (stat.op == OP_DELETE);
      end
      S_WRITE: begin
        cmd.put_write = 1'b1;
        cmd.count_inc = 1'b1;
      end
      S_SHIFT: begin
        cmd.shift_step = 1'b1;
        cmd.count_dec  = stat.scan_end;
      end
      S_LIST_RD:  cmd.list_read = 1'b1;
      S_LIST_OUT: cmd.list_load = stat.out_free;
      S_RESP:     cmd.resp_load = stat.out_free;
      default:    cmd.accept = 1'b0;
    endcase
  end

  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |=> (state == S_DISPATCH))
    else $error("accepted request not dispatched");

  a_resp_done: assert property (@(posedge clk) disable iff (rst)
    cmd.resp_load |=> (state == S_IDLE))
    else $error("sequencer did not return after result load");

  a_one_write: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.count_inc, cmd.count_dec, cmd.count_clr}))
    else $error("conflicting count updates");

endmodule

[sv/directory_name_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// directory_name_table: name to inode table with linear search
// Top level: request sequencer plus storage datapath.
// ----------------------------------------------------------------------------
// One request is taken at a time; in_stall stays high until the request's
// last result has been loaded into the output register. A search decodes
// the request, reads the stored entries through a single read port of the
// name memory, compares each read entry, checks for the end and then loads
// the result. A hit ends the search early. Put adds a write of the new
// entry. Delete goes on from the hit with a shift of the later entries,
// one per cycle on the same port, followed by a compare and an end step.
// List reads and outputs the entries one at a time, newest first, and waits
// whenever the result is stalled. Clear, put on a full table and list on
// an empty table go from decode straight to loading the result.
// The output register holds a result while the next request is taken.
// Names are compared on NAME_BYTES bytes after a cut at the first zero byte.
// ----------------------------------------------------------------------------
module directory_name_table import dnt_pkg::*; #(
  parameter int ENTRIES    = 16,
  parameter int NAME_BYTES = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [OP_W-1:0]     req_type,
  input  logic [WORD_W-1:0]   name_word0,
  input  logic [WORD_W-1:0]   name_word1,
  input  logic [WORD_W-1:0]   name_word2,
  input  logic [WORD_W-1:0]   name_word3,
  input  logic [INODE_W-1:0]  inode_in,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [STATUS_W-1:0] status,
  output logic [INODE_W-1:0]  inode_out,
  output logic [WORD_W-1:0]   out_word0,
  output logic [WORD_W-1:0]   out_word1,
  output logic [WORD_W-1:0]   out_word2,
  output logic [WORD_W-1:0]   out_word3,
  output logic                last_item
);

  dnt_cmd_t  cmd;
  dnt_stat_t stat;
  logic      busy;

  assign in_stall = busy;

  dnt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .busy     (busy),
    .stat     (stat),
    .cmd      (cmd)
  );

  dnt_datapath #(
    .ENTRIES    (ENTRIES),
    .NAME_BYTES (NAME_BYTES)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .req_type   (req_type),
    .name_word0 (name_word0),
    .name_word1 (name_word1),
    .name_word2 (name_word2),
    .name_word3 (name_word3),
    .inode_in   (inode_in),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .status     (status),
    .inode_out  (inode_out),
    .out_word0  (out_word0),
    .out_word1  (out_word1),
    .out_word2  (out_word2),
    .out_word3  (out_word3),
    .last_item  (last_item)
  );

endmodule
